// ===== rtl/assembly_source_lexer_macros.svh =====
// assertion macros for the assembly source lexer
`ifndef ASSEMBLY_SOURCE_LEXER_MACROS_SVH
`define ASSEMBLY_SOURCE_LEXER_MACROS_SVH

// antecedent holds, consequent holds in the same cycle
`define ASL_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent holds, consequent holds in the following cycle
`define ASL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/asl_pkg.sv =====
// types, character codes and helpers for the assembly source lexer
package asl_pkg;

  localparam int OFFSET_W = 32;
  localparam int LEN_W    = 8;
  localparam int LINE_W   = 20;
  localparam int COL_W    = 16;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  localparam logic [COL_W-1:0]    COL_CAP = '1;
  localparam logic [OFFSET_W-1:0] OFF_CAP = '1;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_DIRECTIVE,
    MODE_IDENT,
    MODE_INTEGER,
    MODE_COMMENT,
    MODE_ERRSKIP
  } lex_mode_t;

  typedef enum logic [2:0] {
    KIND_NEWLINE,
    KIND_DIRECTIVE,
    KIND_IDENT,
    KIND_COMMA,
    KIND_COLON,
    KIND_INTEGER,
    KIND_ERROR,
    KIND_END
  } token_kind_t;

  typedef struct packed {
    token_kind_t           kind;
    logic [OFFSET_W-1:0]   offset;
    logic [LEN_W-1:0]      length;
    logic [LINE_W-1:0]     line;
    logic [COL_W-1:0]      column;
    logic                  last;
  } token_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

endpackage

// ===== rtl/assembly_source_lexer.sv =====
// assembly source lexer: one source byte per transfer in, tokens out
//
// s_tdata carries one source byte; a zero byte marks the end of text.
// m_tdata carries one token with its start position; m_tlast marks the
// last token caused by one input byte (a byte can cause up to two).
// An accepted byte sits in the input register until it is processed; then
// the lexer state and position counters update and its tokens enter a
// four-entry result queue, which m_* presents in order. One byte is taken
// per cycle while the queue holds at most two tokens, so the rate is one
// byte per cycle as long as the receiver takes one token per cycle and
// bytes cause at most one token on average. When the receiver stalls, the
// queue fills and s_tready drops once more than two tokens wait; nothing
// is dropped. Reset empties the queue and the input register and returns
// to line 1, column 1, offset 0.
`include "assembly_source_lexer_macros.svh"

module assembly_source_lexer #(
  parameter int MAX_TOKEN_LENGTH = 255,
  parameter int LINE_BITS        = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // char_code
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // token_kind, start_offset, token_length, start_line,
                                 // start_column, zero pad
  output logic        m_tlast
);

  localparam int LenCapInt = (MAX_TOKEN_LENGTH < 255) ? MAX_TOKEN_LENGTH : 255;
  localparam logic [asl_pkg::LEN_W-1:0] LenCap = LenCapInt[asl_pkg::LEN_W-1:0];
  localparam logic [asl_pkg::LINE_W-1:0] LineCap = (LINE_BITS >= 20) ? 20'hFFFFF :
    20'((64'd1 << LINE_BITS) - 64'd1);

  // input register
  logic       in_valid;
  logic [7:0] in_char;
  logic       proc;

  // lexer state
  asl_pkg::lex_mode_t mode, mode_next;
  logic [asl_pkg::OFFSET_W-1:0] tok_offset;
  logic [asl_pkg::LINE_W-1:0]   tok_line;
  logic [asl_pkg::COL_W-1:0]    tok_column;
  logic [asl_pkg::LEN_W-1:0]    tok_count;
  logic [asl_pkg::LINE_W-1:0]   cur_line;
  logic [asl_pkg::COL_W-1:0]    cur_column;
  logic [asl_pkg::OFFSET_W-1:0] cur_offset;

  // result queue
  asl_pkg::token_t q [4];
  logic [1:0] wp, rp;
  logic [2:0] count;
  logic       pop;

  // classification
  logic c_alpha, c_digit, c_nl, c_nul, c_ws, c_unknown;
  logic tok_mode, cont, dispatch, flush_emit, disp_emit, start_tok;
  asl_pkg::token_kind_t disp_kind;
  asl_pkg::token_t first_tok, disp_tok, ent_a, ent_b;

  assign proc     = in_valid && (count <= 3'd2);
  assign s_tready = !in_valid || proc;

  always_comb begin
    c_alpha   = asl_pkg::is_alpha(in_char);
    c_digit   = asl_pkg::is_digit(in_char);
    c_nl      = (in_char == asl_pkg::CH_NL);
    c_nul     = (in_char == asl_pkg::CH_NUL);
    c_ws      = (in_char == asl_pkg::CH_SPACE) || (in_char == asl_pkg::CH_TAB);
    c_unknown = !(c_alpha || c_digit || c_nl || c_nul || c_ws ||
                  in_char == asl_pkg::CH_SEMI || in_char == asl_pkg::CH_DOT ||
                  in_char == asl_pkg::CH_UNDER || in_char == asl_pkg::CH_COMMA ||
                  in_char == asl_pkg::CH_COLON);
    tok_mode  = (mode == asl_pkg::MODE_DIRECTIVE) || (mode == asl_pkg::MODE_IDENT) ||
                (mode == asl_pkg::MODE_INTEGER);
    unique case (mode)
      asl_pkg::MODE_DIRECTIVE: cont = (in_char == asl_pkg::CH_DOT) || c_alpha;
      asl_pkg::MODE_IDENT:     cont = c_alpha || c_digit || (in_char == asl_pkg::CH_UNDER);
      asl_pkg::MODE_INTEGER:   cont = c_digit;
      default:                 cont = 1'b0;
    endcase
    flush_emit = (tok_mode && !cont) ||
                 ((mode == asl_pkg::MODE_ERRSKIP) && (c_nl || c_nul));
    dispatch   = !(tok_mode && cont) &&
                 !((mode == asl_pkg::MODE_COMMENT) && !c_nul) &&
                 !((mode == asl_pkg::MODE_ERRSKIP) && !(c_nl || c_nul));
    start_tok  = dispatch && (in_char == asl_pkg::CH_DOT || c_alpha ||
                 in_char == asl_pkg::CH_UNDER || c_digit);
  end

  // next state
  always_comb begin
    mode_next = mode;
    unique case (mode)
      asl_pkg::MODE_DIRECTIVE,
      asl_pkg::MODE_IDENT,
      asl_pkg::MODE_INTEGER: if (!cont) mode_next = asl_pkg::MODE_IDLE;
      asl_pkg::MODE_COMMENT: if (c_nl || c_nul) mode_next = asl_pkg::MODE_IDLE;
      asl_pkg::MODE_ERRSKIP: if (c_nl || c_nul) mode_next = asl_pkg::MODE_IDLE;
      default:               mode_next = asl_pkg::MODE_IDLE;
    endcase
    if (dispatch) begin
      priority if (in_char == asl_pkg::CH_SEMI) mode_next = asl_pkg::MODE_COMMENT;
      else if (in_char == asl_pkg::CH_DOT) mode_next = asl_pkg::MODE_DIRECTIVE;
      else if (c_alpha || in_char == asl_pkg::CH_UNDER) mode_next = asl_pkg::MODE_IDENT;
      else if (c_digit) mode_next = asl_pkg::MODE_INTEGER;
      else if (c_unknown) mode_next = asl_pkg::MODE_ERRSKIP;
      else mode_next = asl_pkg::MODE_IDLE;
    end
  end

  // emitted tokens
  always_comb begin
    priority if (c_nl) disp_kind = asl_pkg::KIND_NEWLINE;
    else if (in_char == asl_pkg::CH_COMMA) disp_kind = asl_pkg::KIND_COMMA;
    else if (in_char == asl_pkg::CH_COLON) disp_kind = asl_pkg::KIND_COLON;
    else disp_kind = asl_pkg::KIND_END;
    disp_emit = dispatch && (c_nl || c_nul || in_char == asl_pkg::CH_COMMA ||
                in_char == asl_pkg::CH_COLON);

    disp_tok = '{kind: disp_kind, offset: cur_offset, length: 8'd1, line: cur_line,
                 column: cur_column, last: 1'b1};

    unique case (mode)
      asl_pkg::MODE_DIRECTIVE: first_tok.kind = asl_pkg::KIND_DIRECTIVE;
      asl_pkg::MODE_IDENT:     first_tok.kind = asl_pkg::KIND_IDENT;
      asl_pkg::MODE_INTEGER:   first_tok.kind = asl_pkg::KIND_INTEGER;
      default:                 first_tok.kind = asl_pkg::KIND_ERROR;
    endcase
    if (tok_mode) begin
      first_tok.offset = tok_offset;
      first_tok.length = tok_count;
      first_tok.line   = tok_line;
      first_tok.column = tok_column;
    end else begin
      first_tok.offset = cur_offset;
      first_tok.length = 8'd1;
      first_tok.line   = cur_line;
      first_tok.column = cur_column;
    end
    first_tok.last = !disp_emit;

    ent_a = flush_emit ? first_tok : disp_tok;
    ent_b = disp_tok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_char <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= asl_pkg::MODE_IDLE;
      tok_offset <= '0;
      tok_line   <= 20'd1;
      tok_column <= 16'd1;
      tok_count  <= '0;
      cur_line   <= 20'd1;
      cur_column <= 16'd1;
      cur_offset <= '0;
    end else if (proc) begin
      mode <= mode_next;
      if (tok_mode && cont && tok_count < LenCap) begin
        tok_count <= tok_count + 8'd1;
      end
      if (start_tok) begin
        tok_offset <= cur_offset;
        tok_line   <= cur_line;
        tok_column <= cur_column;
        tok_count  <= 8'd1;
      end
      if (!c_nul) begin
        if (c_nl) begin
          if (cur_line < LineCap) cur_line <= cur_line + 20'd1;
          cur_column <= 16'd1;
        end else if (cur_column < asl_pkg::COL_CAP) begin
          cur_column <= cur_column + 16'd1;
        end
        if (cur_offset < asl_pkg::OFF_CAP) cur_offset <= cur_offset + 32'd1;
      end
    end
  end

  // result queue
  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = (count != 3'd0);
  assign m_tdata  = {1'b0, q[rp].column, q[rp].line, q[rp].length, q[rp].offset,
                     q[rp].kind};
  assign m_tlast  = q[rp].last;

  logic [2:0] n_push;
  assign n_push = proc ? (3'(flush_emit) + 3'(disp_emit)) : 3'd0;

  always_ff @(posedge clk) begin
    if (n_push != 3'd0) q[wp] <= ent_a;
    if (n_push == 3'd2) q[wp + 2'd1] <= ent_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + n_push[1:0];
      rp    <= rp + 2'(pop);
      count <= count + n_push - 3'(pop);
    end
  end

  `ASL_ASSERT_SAME(a_queue_bound, 1'b1, count <= 3'd4, "result queue overflow")
  `ASL_ASSERT_SAME(a_token_count, tok_mode, tok_count != 8'd0,
    "open token with zero length")
  `ASL_ASSERT_NEXT(a_offset_mono, 1'b1, cur_offset >= $past(cur_offset),
    "offset went backward")
  `ASL_ASSERT_NEXT(a_line_step, proc && c_nl && cur_line < LineCap,
    cur_line == $past(cur_line) + 20'd1 && cur_column == 16'd1,
    "newline did not advance line")

endmodule

// ===== dv/assembly_source_lexer_tb.sv =====
// testbench for the assembly source lexer: byte stream in, tokens checked against a predictor
module assembly_source_lexer_tb;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int RAND_ITEMS  = 350;
  localparam int DRAIN       = 20;
  localparam int DIR_N       = 28;

  localparam logic [asl_pkg::LEN_W-1:0]  LEN_MAX  = '1;
  localparam logic [asl_pkg::LINE_W-1:0] LINE_MAX = '1;

  localparam int KIND_LO = 0;
  localparam int OFF_LO  = 3;
  localparam int LEN_LO  = OFF_LO + asl_pkg::OFFSET_W;
  localparam int LINE_LO = LEN_LO + asl_pkg::LEN_W;
  localparam int COL_LO  = LINE_LO + asl_pkg::LINE_W;

  typedef struct packed {
    logic [7:0]                   ch;
    logic                         typed;
    asl_pkg::token_kind_t         kind;
    logic [asl_pkg::OFFSET_W-1:0] off;
    logic [asl_pkg::LINE_W-1:0]   line;
    logic [asl_pkg::COL_W-1:0]    col;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;
  logic        m_tlast;

  dir_row_t dir_rows [DIR_N] = '{
    '{asl_pkg::CH_NUL,   1'b1, asl_pkg::KIND_END,     32'd0, 20'd1, 16'd1},
    '{asl_pkg::CH_COMMA, 1'b1, asl_pkg::KIND_COMMA,   32'd0, 20'd1, 16'd1},
    '{asl_pkg::CH_COLON, 1'b1, asl_pkg::KIND_COLON,   32'd1, 20'd1, 16'd2},
    '{asl_pkg::CH_NL,    1'b1, asl_pkg::KIND_NEWLINE, 32'd2, 20'd1, 16'd3},
    '{asl_pkg::CH_DOT,   1'b0, asl_pkg::KIND_NEWLINE, 32'd0, 20'd0, 16'd0},
    '{asl_pkg::CH_DOT,   1'b0, asl_pkg::KIND_NEWLINE, 32'd0, 20'd0, 16'd0},
    '{8'h7A,             1'b0, asl_pkg::KIND_NEWLINE, 32'd0, 20'd0, 16'd0},
    '{asl_pkg::CH_UNDER, 1'b0, asl_pkg::KIND_NEWLINE, 32'd0, 20'd0, 16'd0},
    '{8'h5A,             1'b0, asl_pkg::KIND_NEWLINE, 32'd0, 20'd0, 16'd0},
    '{8'h39,             1'b0, asl_pkg::KIND_NEWLINE, 32'd0, 20'd0, 16'd0},
    '{asl_pkg::CH_COMMA, 1'b0, asl_pkg::KIND_NEWLINE, 32'd0, 20'd0, 16'd0},
    '{8'h30,             1'b0, asl_pkg::KIND_NEWLINE, 32'd0, 20'd0, 16'd0},
    '{8'h41,             1'b0, asl_pkg::KIND_NEWLINE, 32'd0, 20'd0, 16'd0},
    '{asl_pkg::CH_TAB,   1'b0, asl_pkg::KIND_NEWLINE, 32'd0, 20'd0, 16'd0},
    '{asl_pkg::CH_SEMI,  1'b0, asl_pkg::KIND_NEWLINE, 32'd0, 20'd0, 16'd0},
    '{8'hFF,             1'b0, asl_pkg::KIND_NEWLINE, 32'd0, 20'd0, 16'd0},
    '{asl_pkg::CH_NL,    1'b0, asl_pkg::KIND_NEWLINE, 32'd0, 20'd0, 16'd0},
    '{8'h80,             1'b0, asl_pkg::KIND_NEWLINE, 32'd0, 20'd0, 16'd0},
    '{asl_pkg::CH_NUL,   1'b0, asl_pkg::KIND_NEWLINE, 32'd0, 20'd0, 16'd0},
    '{8'h24,             1'b0, asl_pkg::KIND_NEWLINE, 32'd0, 20'd0, 16'd0},
    '{8'h61,             1'b0, asl_pkg::KIND_NEWLINE, 32'd0, 20'd0, 16'd0},
    '{asl_pkg::CH_NL,    1'b0, asl_pkg::KIND_NEWLINE, 32'd0, 20'd0, 16'd0},
    '{8'h39,             1'b0, asl_pkg::KIND_NEWLINE, 32'd0, 20'd0, 16'd0},
    '{asl_pkg::CH_NUL,   1'b0, asl_pkg::KIND_NEWLINE, 32'd0, 20'd0, 16'd0},
    '{asl_pkg::CH_SEMI,  1'b0, asl_pkg::KIND_NEWLINE, 32'd0, 20'd0, 16'd0},
    '{asl_pkg::CH_NUL,   1'b0, asl_pkg::KIND_NEWLINE, 32'd0, 20'd0, 16'd0},
    '{8'h7F,             1'b0, asl_pkg::KIND_NEWLINE, 32'd0, 20'd0, 16'd0},
    '{asl_pkg::CH_NL,    1'b0, asl_pkg::KIND_NEWLINE, 32'd0, 20'd0, 16'd0}
  };

  logic [7:0]      src_bytes [$];
  asl_pkg::token_t step_toks [$];
  asl_pkg::token_t pending_tokens [$];

  asl_pkg::lex_mode_t           lx_mode  = asl_pkg::MODE_IDLE;
  logic [asl_pkg::OFFSET_W-1:0] tok_off  = '0;
  logic [asl_pkg::LINE_W-1:0]   tok_line = 20'd1;
  logic [asl_pkg::COL_W-1:0]    tok_col  = 16'd1;
  logic [asl_pkg::LEN_W-1:0]    tok_len  = '0;
  logic [asl_pkg::LINE_W-1:0]   cur_line = 20'd1;
  logic [asl_pkg::COL_W-1:0]    cur_col  = 16'd1;
  logic [asl_pkg::OFFSET_W-1:0] cur_off  = '0;

  int  bytes_taken    = 0;
  int  cycle_cnt      = 0;
  int  mismatch_count = 0;
  int  hold_left      = 0;
  bit  hold_done      = 1'b0;
  logic quiet;

  assign quiet = bytes_taken >= 650 && bytes_taken < 850;

  assembly_source_lexer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  function automatic logic is_letter_byte(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_decimal_byte(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  // predictor
  task automatic advance_pos(input logic [7:0] c);
    if (c == asl_pkg::CH_NL) begin
      if (cur_line < LINE_MAX) cur_line++;
      cur_col = 16'd1;
    end else if (cur_col < asl_pkg::COL_CAP) begin
      cur_col++;
    end
    if (cur_off < asl_pkg::OFF_CAP) cur_off++;
  endtask

  task automatic emit_tok(input asl_pkg::token_kind_t k,
                          input logic [asl_pkg::OFFSET_W-1:0] off,
                          input logic [asl_pkg::LEN_W-1:0] len,
                          input logic [asl_pkg::LINE_W-1:0] ln,
                          input logic [asl_pkg::COL_W-1:0] col);
    asl_pkg::token_t t;
    t.kind   = k;
    t.offset = off;
    t.length = len;
    t.line   = ln;
    t.column = col;
    t.last   = 1'b0;
    step_toks.push_back(t);
  endtask

  task automatic start_tok(input asl_pkg::lex_mode_t m);
    lx_mode  = m;
    tok_off  = cur_off;
    tok_line = cur_line;
    tok_col  = cur_col;
    tok_len  = 8'd1;
  endtask

  task automatic lex_byte(input logic [7:0] c);
    logic            cont;
    logic            dispatch;
    asl_pkg::token_t t;
    step_toks.delete();
    dispatch = 1'b1;
    case (lx_mode)
      asl_pkg::MODE_DIRECTIVE, asl_pkg::MODE_IDENT, asl_pkg::MODE_INTEGER: begin
        if (lx_mode == asl_pkg::MODE_DIRECTIVE)
          cont = c == asl_pkg::CH_DOT || is_letter_byte(c);
        else if (lx_mode == asl_pkg::MODE_IDENT)
          cont = is_letter_byte(c) || is_decimal_byte(c) || c == asl_pkg::CH_UNDER;
        else cont = is_decimal_byte(c);
        if (cont) begin
          if (tok_len < LEN_MAX) tok_len++;
          advance_pos(c);
          dispatch = 1'b0;
        end else begin
          emit_tok(lx_mode == asl_pkg::MODE_DIRECTIVE ? asl_pkg::KIND_DIRECTIVE :
                   lx_mode == asl_pkg::MODE_IDENT ? asl_pkg::KIND_IDENT :
                   asl_pkg::KIND_INTEGER,
                   tok_off, tok_len, tok_line, tok_col);
          lx_mode = asl_pkg::MODE_IDLE;
        end
      end
      asl_pkg::MODE_COMMENT: begin
        if (c == asl_pkg::CH_NUL) begin
          lx_mode = asl_pkg::MODE_IDLE;
        end else begin
          if (c == asl_pkg::CH_NL) lx_mode = asl_pkg::MODE_IDLE;
          advance_pos(c);
          dispatch = 1'b0;
        end
      end
      asl_pkg::MODE_ERRSKIP: begin
        if (c == asl_pkg::CH_NL || c == asl_pkg::CH_NUL) begin
          emit_tok(asl_pkg::KIND_ERROR, cur_off, 8'd1, cur_line, cur_col);
          lx_mode = asl_pkg::MODE_IDLE;
        end else begin
          advance_pos(c);
          dispatch = 1'b0;
        end
      end
      default: lx_mode = asl_pkg::MODE_IDLE;
    endcase
    if (dispatch) begin
      if (c == asl_pkg::CH_NL) begin
        emit_tok(asl_pkg::KIND_NEWLINE, cur_off, 8'd1, cur_line, cur_col);
        advance_pos(c);
      end else if (c == asl_pkg::CH_SPACE || c == asl_pkg::CH_TAB) begin
        advance_pos(c);
      end else if (c == asl_pkg::CH_SEMI) begin
        lx_mode = asl_pkg::MODE_COMMENT;
        advance_pos(c);
      end else if (c == asl_pkg::CH_DOT) begin
        start_tok(asl_pkg::MODE_DIRECTIVE);
        advance_pos(c);
      end else if (is_letter_byte(c) || c == asl_pkg::CH_UNDER) begin
        start_tok(asl_pkg::MODE_IDENT);
        advance_pos(c);
      end else if (is_decimal_byte(c)) begin
        start_tok(asl_pkg::MODE_INTEGER);
        advance_pos(c);
      end else if (c == asl_pkg::CH_COMMA) begin
        emit_tok(asl_pkg::KIND_COMMA, cur_off, 8'd1, cur_line, cur_col);
        advance_pos(c);
      end else if (c == asl_pkg::CH_COLON) begin
        emit_tok(asl_pkg::KIND_COLON, cur_off, 8'd1, cur_line, cur_col);
        advance_pos(c);
      end else if (c == asl_pkg::CH_NUL) begin
        emit_tok(asl_pkg::KIND_END, cur_off, 8'd1, cur_line, cur_col);
      end else begin
        lx_mode = asl_pkg::MODE_ERRSKIP;
        advance_pos(c);
      end
    end
    if (step_toks.size() > 0) begin
      t = step_toks.pop_back();
      t.last = 1'b1;
      step_toks.push_back(t);
    end
  endtask

  // stimulus generation
  function automatic logic [7:0] rand_letter();
    logic [7:0] base;
    base = $urandom_range(0, 1) ? 8'h61 : 8'h41;
    return base + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_unknown();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (is_letter_byte(c) || is_decimal_byte(c) || c == asl_pkg::CH_NUL ||
           c == asl_pkg::CH_TAB || c == asl_pkg::CH_NL || c == asl_pkg::CH_SPACE ||
           c == asl_pkg::CH_COMMA || c == asl_pkg::CH_DOT || c == asl_pkg::CH_COLON ||
           c == asl_pkg::CH_SEMI || c == asl_pkg::CH_UNDER);
    return c;
  endfunction

  function automatic int word_len();
    return $urandom_range(0, 59) == 0 ? $urandom_range(256, 300) : $urandom_range(1, 8);
  endfunction

  task automatic put_gap();
    repeat ($urandom_range(0, 2))
      src_bytes.push_back($urandom_range(0, 3) == 0 ? asl_pkg::CH_TAB : asl_pkg::CH_SPACE);
  endtask

  task automatic put_ident(input int len);
    int r;
    src_bytes.push_back($urandom_range(0, 9) == 0 ? asl_pkg::CH_UNDER : rand_letter());
    repeat (len - 1) begin
      r = $urandom_range(0, 5);
      if (r == 0) src_bytes.push_back(asl_pkg::CH_UNDER);
      else if (r < 3) src_bytes.push_back(8'h30 + 8'($urandom_range(0, 9)));
      else src_bytes.push_back(rand_letter());
    end
  endtask

  task automatic put_number(input int len);
    repeat (len) src_bytes.push_back(8'h30 + 8'($urandom_range(0, 9)));
  endtask

  task automatic put_line(input logic broken);
    int         ops;
    logic [7:0] b;
    if ($urandom_range(0, 3) == 0) begin
      put_ident(word_len());
      src_bytes.push_back(asl_pkg::CH_COLON);
      put_gap();
    end
    if ($urandom_range(0, 2) == 0) begin
      src_bytes.push_back(asl_pkg::CH_DOT);
      repeat (word_len() - 1)
        src_bytes.push_back($urandom_range(0, 4) == 0 ? asl_pkg::CH_DOT : rand_letter());
    end else begin
      put_ident(word_len());
    end
    src_bytes.push_back(asl_pkg::CH_SPACE);
    ops = $urandom_range(0, 3);
    for (int k = 0; k < ops; k++) begin
      if (k > 0) begin
        src_bytes.push_back(asl_pkg::CH_COMMA);
        put_gap();
      end
      if (broken && k == ops - 1) src_bytes.push_back(rand_unknown());
      if ($urandom_range(0, 1)) put_ident(word_len());
      else put_number(word_len());
    end
    if (broken && ops == 0) src_bytes.push_back(rand_unknown());
    if (broken || $urandom_range(0, 3) == 0) begin
      put_gap();
      src_bytes.push_back(asl_pkg::CH_SEMI);
      repeat ($urandom_range(0, 10)) begin
        b = 8'($urandom_range(1, 255));
        if (b == asl_pkg::CH_NL) b = asl_pkg::CH_SPACE;
        src_bytes.push_back(b);
      end
    end
    src_bytes.push_back($urandom_range(0, 15) == 0 ? asl_pkg::CH_NUL : asl_pkg::CH_NL);
  endtask

  initial begin : build_stimulus
    int pick;
    int rand_end;
    for (int i = 0; i < DIR_N; i++) src_bytes.push_back(dir_rows[i].ch);
    // tokens past the length cap
    put_ident(258);
    src_bytes.push_back(asl_pkg::CH_SPACE);
    put_number(257);
    src_bytes.push_back(asl_pkg::CH_NL);
    rand_end = src_bytes.size() + RAND_ITEMS;
    while (src_bytes.size() < rand_end) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) put_line(1'b0);
      else if (pick < 80) put_line(1'b1);
      else if (pick < 92)
        repeat ($urandom_range(1, 8)) src_bytes.push_back(8'($urandom_range(0, 255)));
      else if (pick < 96) src_bytes.push_back(asl_pkg::CH_NUL);
      else src_bytes.push_back(asl_pkg::CH_NL);
    end
    // end of text
    src_bytes.push_back(asl_pkg::CH_NL);
    put_ident(2);
    src_bytes.push_back(asl_pkg::CH_COMMA);
    src_bytes.push_back(asl_pkg::CH_NL);
    src_bytes.push_back(asl_pkg::CH_NUL);
  end

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  // byte source and prediction on every transfer
  always @(posedge clk) begin : feed
    int              nxt;
    asl_pkg::token_t t;
    nxt = bytes_taken;
    if (!rst && s_tvalid && s_tready) begin
      lex_byte(s_tdata);
      if (nxt < DIR_N && dir_rows[nxt].typed) begin
        t.kind   = dir_rows[nxt].kind;
        t.offset = dir_rows[nxt].off;
        t.length = 8'd1;
        t.line   = dir_rows[nxt].line;
        t.column = dir_rows[nxt].col;
        t.last   = 1'b1;
        pending_tokens.push_back(t);
      end else begin
        foreach (step_toks[i]) pending_tokens.push_back(step_toks[i]);
      end
      nxt = nxt + 1;
    end
    bytes_taken <= nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (nxt < src_bytes.size() && (quiet || $urandom_range(0, 99) >= 8)) begin
        s_tvalid <= 1'b1;
        s_tdata  <= src_bytes[nxt];
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // token sink, with one long hold-off to back up the block
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && bytes_taken >= 600) begin
      hold_done <= 1'b1;
      hold_left <= 300;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= quiet || $urandom_range(0, 99) >= 8;
    end
  end

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : check
    asl_pkg::token_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_tokens.size() == 0) begin
        $error("token transfer with nothing expected: tdata %h", m_tdata);
        mismatch_count++;
      end else begin
        want = pending_tokens.pop_front();
        check_field("token_kind", 32'(want.kind), 32'(m_tdata[KIND_LO +: 3]));
        check_field("start_offset", want.offset, m_tdata[OFF_LO +: asl_pkg::OFFSET_W]);
        check_field("token_length", 32'(want.length),
                    32'(m_tdata[LEN_LO +: asl_pkg::LEN_W]));
        check_field("start_line", 32'(want.line), 32'(m_tdata[LINE_LO +: asl_pkg::LINE_W]));
        check_field("start_column", 32'(want.column),
                    32'(m_tdata[COL_LO +: asl_pkg::COL_W]));
        check_field("last_of_run", 32'(want.last), 32'(m_tlast));
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    while (rst || bytes_taken < src_bytes.size() || pending_tokens.size() != 0)
      @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (mismatch_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
